// File: design/sorted_index_table_macros.svh
// Assertion macros for the sorted index table.
// Needs nothing; included by sit_ctrl, which checks its own logic.
`ifndef SORTED_INDEX_TABLE_MACROS_SVH
`define SORTED_INDEX_TABLE_MACROS_SVH

// same-cycle implication, off during reset
`define SIT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sorted_index_table: assertion failed");

// next-cycle implication, off during reset
`define SIT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted_index_table: assertion failed");

`endif

// File: design/sit_pkg.sv
// Shared types and codes of the sorted index table.
// No dependencies; imported by sit_cell, sit_ctrl and sorted_index_table.
`default_nettype none
package sit_pkg;

   localparam int KEY_W   = 72;
   localparam int SLOT_W  = 6;
   localparam int STAT_W  = 2;
   localparam int ACT_W   = 2;
   localparam int IPOS_W  = 7;
   // position carried by the search token; covers tables up to 2048 entries
   localparam int POS_W   = 11;

   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
   localparam logic [ACT_W-1:0] ACT_LIST   = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [SLOT_W-1:0] slot;
   } ent_type;

   // token that walks the cell row, one cell per cycle
   typedef struct packed {
      logic              valid;
      logic              is_ins;     // insert, else lookup
      logic              has_entry;  // an entry is still being carried
      logic              is_new;     // search position not yet found
      logic              found;
      logic [KEY_W-1:0]  key;
      logic [SLOT_W-1:0] slot;
      logic [POS_W-1:0]  pos;
   } tok_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_WALK,
      FSM_EMIT,
      FSM_LIST
   } fsm_type;

endpackage
`default_nettype wire

// File: design/sit_cell.sv
// One cell of the sorted row: holds one entry and passes the token on.
// Depends on sit_pkg.
`default_nettype none
module sit_cell
   import sit_pkg::*;
#(
   parameter int IDX = 0,
   parameter int LAST_IDX = 63,
   parameter int CW = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [CW-1:0] count,
   input  wire logic          rotate,
   input  wire tok_type       tok_prev,
   output tok_type            tok_next,
   input  wire ent_type       ent_nbr,
   input  wire ent_type       ent_head,
   output ent_type            ent_out
);

   ent_type ent_ff, ent_in;
   tok_type tok_ff, tok_in;
   logic    lt, here, at_end, wrap;

   always_comb begin
      lt     = ent_ff.key < tok_prev.key;
      here   = CW'(IDX) < count;
      at_end = CW'(IDX) == count;
      wrap   = (CW'(IDX + 1) == count) || (IDX == LAST_IDX);
      ent_in = ent_ff;
      tok_in = tok_prev;
      if (rotate) begin
         // shift toward the head, head entry wraps to the last used cell
         ent_in = (CW'(IDX + 1) == count) ? ent_head : ent_nbr;
         if (!wrap) ent_in = ent_nbr;
      end else if (tok_prev.valid) begin
         if (tok_prev.is_ins && tok_prev.has_entry) begin
            if (here && (!tok_prev.is_new || !lt)) begin
               // swap: keep the carried entry, hand ours down the row
               ent_in.key  = tok_prev.key;
               ent_in.slot = tok_prev.slot;
               tok_in.key  = ent_ff.key;
               tok_in.slot = ent_ff.slot;
               if (tok_prev.is_new) begin
                  tok_in.pos    = POS_W'(IDX);
                  tok_in.is_new = 1'b0;
               end
            end else if (at_end) begin
               ent_in.key       = tok_prev.key;
               ent_in.slot      = tok_prev.slot;
               tok_in.has_entry = 1'b0;
               if (tok_prev.is_new) begin
                  tok_in.pos    = POS_W'(IDX);
                  tok_in.is_new = 1'b0;
               end
            end
         end else if (!tok_prev.is_ins && tok_prev.is_new && here && !lt) begin
            tok_in.pos    = POS_W'(IDX);
            tok_in.is_new = 1'b0;
            tok_in.found  = ent_ff.key == tok_prev.key;
            tok_in.slot   = ent_ff.slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_next = tok_ff;
   assign ent_out  = ent_ff;

endmodule
`default_nettype wire

// File: design/sit_ctrl.sv
// Sequencer of the sorted index table: takes requests, launches tokens,
// drives the list rotation and holds the result register. Depends on sit_pkg.
`default_nettype none
`include "sorted_index_table_macros.svh"
module sit_ctrl
   import sit_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int CW = 7
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [ACT_W-1:0]   req_action,
   input  wire logic [63:0]        req_key_hi,
   input  wire logic [7:0]         req_key_lo,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [STAT_W-1:0]       rsp_status,
   output logic [IPOS_W-1:0]      rsp_index_pos,
   output logic [SLOT_W-1:0]       rsp_data_pos,
   output logic [63:0]             rsp_out_key_hi,
   output logic [7:0]              rsp_out_key_lo,
   output logic                    rsp_last,
   output tok_type                 tok_inject,
   input  wire tok_type            tok_tail,
   input  wire ent_type            ent_head,
   output logic                    rotate,
   output logic [CW-1:0]           count
);

   fsm_type             state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       lst_n_ff, lst_n_in;
   tok_type             inj_ff, inj_in;
   logic [STAT_W-1:0]   pend_stat_ff, pend_stat_in;
   logic [CW-1:0]       pend_pos_ff, pend_pos_in;
   logic [SLOT_W-1:0]   pend_slot_ff, pend_slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   rsp_stat_ff, rsp_stat_in;
   logic [IPOS_W-1:0]   rsp_ipos_ff, rsp_ipos_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                out_free, accept, lst_end;

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      accept       = req_valid && (state_ff == FSM_IDLE);
      lst_end      = CW'(lst_n_ff + 1'b1) == count_ff;
      state_in     = state_ff;
      count_in     = count_ff;
      lst_n_in     = lst_n_ff;
      inj_in       = inj_ff;
      inj_in.valid = 1'b0;
      pend_stat_in = pend_stat_ff;
      pend_pos_in  = pend_pos_ff;
      pend_slot_in = pend_slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_ipos_in  = rsp_ipos_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_last_in  = rsp_last_ff;
      rotate       = 1'b0;

      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               inj_in.is_ins    = 1'b0;
               inj_in.has_entry = 1'b0;
               inj_in.is_new    = 1'b1;
               inj_in.found     = 1'b0;
               inj_in.key       = {req_key_hi, req_key_lo};
               inj_in.slot      = SLOT_W'(count_ff);
               inj_in.pos       = '0;
               pend_pos_in      = '0;
               pend_slot_in     = '0;
               pend_stat_in     = ST_EMPTY;
               case (req_action)
                  ACT_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        pend_stat_in = ST_FULL;
                        pend_pos_in  = count_ff;
                        state_in     = FSM_EMIT;
                     end else begin
                        inj_in.valid     = 1'b1;
                        inj_in.is_ins    = 1'b1;
                        inj_in.has_entry = 1'b1;
                        state_in         = FSM_WALK;
                     end
                  end
                  ACT_LOOKUP: begin
                     if (count_ff == '0) begin
                        state_in = FSM_EMIT;
                     end else begin
                        inj_in.valid = 1'b1;
                        state_in     = FSM_WALK;
                     end
                  end
                  ACT_LIST: begin
                     lst_n_in = '0;
                     state_in = (count_ff == '0) ? FSM_EMIT : FSM_LIST;
                  end
                  default: begin
                     // unused code: drop the beat
                     state_in = FSM_IDLE;
                  end
               endcase
            end
         end
         FSM_WALK: begin
            if (tok_tail.valid) begin
               if (tok_tail.is_ins) begin
                  pend_stat_in = ST_OK;
                  pend_pos_in  = CW'(tok_tail.pos);
                  pend_slot_in = SLOT_W'(count_ff);
                  count_in     = CW'(count_ff + 1'b1);
               end else if (!tok_tail.is_new && tok_tail.found) begin
                  pend_stat_in = ST_OK;
                  pend_pos_in  = CW'(tok_tail.pos);
                  pend_slot_in = tok_tail.slot;
               end else begin
                  pend_stat_in = ST_NOTFOUND;
                  pend_pos_in  = tok_tail.is_new ? count_ff : CW'(tok_tail.pos);
                  pend_slot_in = '0;
               end
               state_in = FSM_EMIT;
            end
         end
         FSM_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = pend_stat_ff;
               rsp_ipos_in  = IPOS_W'(pend_pos_ff);
               rsp_slot_in  = pend_slot_ff;
               rsp_key_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = FSM_IDLE;
            end
         end
         FSM_LIST: begin
            if (out_free) begin
               // emit the head entry and rotate the row by one
               rsp_valid_in = 1'b1;
               rsp_stat_in  = ST_OK;
               rsp_ipos_in  = IPOS_W'(lst_n_ff);
               rsp_slot_in  = ent_head.slot;
               rsp_key_in   = ent_head.key;
               rsp_last_in  = lst_end;
               rotate       = 1'b1;
               lst_n_in     = CW'(lst_n_ff + 1'b1);
               if (lst_end) state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         inj_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         inj_ff       <= inj_in;
      end
      lst_n_ff     <= lst_n_in;
      pend_stat_ff <= pend_stat_in;
      pend_pos_ff  <= pend_pos_in;
      pend_slot_ff <= pend_slot_in;
      rsp_stat_ff  <= rsp_stat_in;
      rsp_ipos_ff  <= rsp_ipos_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready      = state_ff == FSM_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_stat_ff;
   assign rsp_index_pos  = rsp_ipos_ff;
   assign rsp_data_pos   = rsp_slot_ff;
   assign rsp_out_key_hi = rsp_key_ff[KEY_W-1:8];
   assign rsp_out_key_lo = rsp_key_ff[7:0];
   assign rsp_last       = rsp_last_ff;
   assign tok_inject     = inj_ff;
   assign count          = count_ff;

   `SIT_ASSERT(a_count_range, clock, reset, count_ff <= CW'(DEPTH))
   `SIT_ASSERT(a_tail_in_walk, clock, reset, tok_tail.valid |-> state_ff == FSM_WALK)
   `SIT_ASSERT(a_count_step, clock, reset,
      (!$past(reset) && count_ff != $past(count_ff)) |->
      count_ff == CW'($past(count_ff) + 1'b1))
   `SIT_ASSERT_NEXT(a_list_start, clock, reset,
      accept && req_action == ACT_LIST && count_ff != '0, state_ff == FSM_LIST)

endmodule
`default_nettype wire

// File: design/sorted_index_table.sv
// Top level of the sorted index table: a row of DEPTH cells plus sequencer.
// Depends on sit_pkg, sit_cell and sit_ctrl.
//
//   channel   direction  handshake              beat
//   req_      in         req_valid/req_ready    action, 72-bit key
//   rsp_      out        rsp_valid/rsp_ready    status, positions, key, last
//
// Insert and lookup: a token walks the cell row one cell per cycle; the result
// is loaded after the inject register, DEPTH cell steps and tail capture, once
// the output is free, and the next request is taken after that load.
// Full insert, empty lookup or list: no token walk before the result load.
// List: one beat per cycle for entry_count beats while the output is free;
// the row rotates once per beat; a stalled rsp_ready holds it, nothing is lost.
// Reset clears the count, not the entries; the table is empty at once, no sweep.
`default_nettype none
module sorted_index_table
   import sit_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [ACT_W-1:0]   req_action,
   input  wire logic [63:0]        req_key_hi,
   input  wire logic [7:0]         req_key_lo,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [STAT_W-1:0]       rsp_status,
   output logic [IPOS_W-1:0]       rsp_index_pos,
   output logic [SLOT_W-1:0]       rsp_data_pos,
   output logic [63:0]             rsp_out_key_hi,
   output logic [7:0]              rsp_out_key_lo,
   output logic                    rsp_last
);

   localparam int CW = $clog2(DEPTH + 1);

   tok_type       tok_link [0:DEPTH];
   ent_type       ent_q    [0:DEPTH-1];
   logic          rotate;
   logic [CW-1:0] count;

   sit_ctrl #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_key_hi     (req_key_hi),
      .req_key_lo     (req_key_lo),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_index_pos  (rsp_index_pos),
      .rsp_data_pos   (rsp_data_pos),
      .rsp_out_key_hi (rsp_out_key_hi),
      .rsp_out_key_lo (rsp_out_key_lo),
      .rsp_last       (rsp_last),
      .tok_inject     (tok_link[0]),
      .tok_tail       (tok_link[DEPTH]),
      .ent_head       (ent_q[0]),
      .rotate         (rotate),
      .count          (count)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      ent_type nbr;
      if (i == DEPTH - 1) begin : g_end
         assign nbr = ent_q[0];
      end else begin : g_mid
         assign nbr = ent_q[i+1];
      end
      sit_cell #(
         .IDX      (i),
         .LAST_IDX (DEPTH - 1),
         .CW       (CW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .count    (count),
         .rotate   (rotate),
         .tok_prev (tok_link[i]),
         .tok_next (tok_link[i+1]),
         .ent_nbr  (nbr),
         .ent_head (ent_q[0]),
         .ent_out  (ent_q[i])
      );
   end

endmodule
`default_nettype wire
